### hw/rtl/ale_pkg.sv
// shared types, field widths, action and status codes for the array list engine
package ale_pkg;

  localparam int VAL_W = 32;
  localparam int AMT_W = 16;

  localparam logic [3:0] ACT_INS_FRONT = 4'd0;
  localparam logic [3:0] ACT_INS_END   = 4'd1;
  localparam logic [3:0] ACT_INS_POS   = 4'd2;
  localparam logic [3:0] ACT_DEL_FRONT = 4'd3;
  localparam logic [3:0] ACT_DEL_END   = 4'd4;
  localparam logic [3:0] ACT_DEL_POS   = 4'd5;
  localparam logic [3:0] ACT_SEARCH    = 4'd6;
  localparam logic [3:0] ACT_READOUT   = 4'd7;
  localparam logic [3:0] ACT_ROTATE    = 4'd8;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_BADPOS   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [3:0]              action;
    logic [7:0]              position;
    logic signed [VAL_W-1:0] value;
    logic [AMT_W-1:0]        rotate_amount;
  } req_t;

  typedef struct packed {
    logic [2:0]              status;
    logic [3:0]              found_position;
    logic signed [VAL_W-1:0] element;
    logic [3:0]              count;
    logic                    last;
  } rsp_t;

endpackage

### hw/rtl/ale_ram.sv
// element bank: one write port, one read port with registered read data
module ale_ram #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [ale_pkg::VAL_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [ale_pkg::VAL_W-1:0] rdata
);
  import ale_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/ale_mod.sv
// restoring remainder unit, one dividend bit per cycle
module ale_mod #(
  parameter int CW = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ale_pkg::AMT_W-1:0] dividend,
  input  logic [CW-1:0]             divisor,
  output logic                      done,
  output logic [CW-1:0]             rem
);
  import ale_pkg::*;

  localparam int NW = $clog2(AMT_W + 1);

  logic             busy;
  logic [NW-1:0]    steps;
  logic [AMT_W-1:0] quo;
  logic [CW-1:0]    dvs;
  logic [CW:0]      trial;

  // remainder stays below divisor, so the shifted trial fits in CW+1 bits
  assign trial = {rem, quo[AMT_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= NW'(AMT_W);
        quo   <= dividend;
        dvs   <= divisor;
        rem   <= '0;
      end else if (busy) begin
        quo <= {quo[AMT_W-2:0], 1'b0};
        if (trial >= {1'b0, dvs}) begin
          rem <= CW'(trial - {1'b0, dvs});
        end else begin
          rem <= trial[CW-1:0];
        end
        steps <= steps - NW'(1);
        if (steps == NW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/array_list_engine_unit.sv
// array list engine: ordered list in two ping-pong banks with a sequencer
// a dispatch state first; then shifting inserts, deletes and rotate copy the list into the
// other bank, search walks the list until a match, readout emits one word per element;
// rotate first waits for the remainder unit; delete at end and error cases answer directly
// one item at a time; the single bank read port walks one element per cycle unless stalled
// synchronous reset empties the list and the output register; bank contents are not cleared
module array_list_engine_unit #(
  parameter int DEPTH = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ale_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ale_pkg::rsp_t rsp
);
  import ale_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = ((CW > 8) ? CW : 8) + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DISP   = 3'd1;
  localparam logic [2:0] S_MOD    = 3'd2;
  localparam logic [2:0] S_COPY   = 3'd3;
  localparam logic [2:0] S_SEARCH = 3'd4;
  localparam logic [2:0] S_READ   = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  localparam logic [1:0] M_INS = 2'd0;
  localparam logic [1:0] M_DEL = 2'd1;
  localparam logic [1:0] M_ROT = 2'd2;

  logic [2:0]       state;
  req_t             op;
  logic [CW-1:0]    cnt;
  logic             cur;
  logic [AW-1:0]    s;
  logic [AW-1:0]    dp;
  logic [AW-1:0]    idx;
  logic [1:0]       mode;
  logic [2:0]       st;
  logic [3:0]       fpos;

  logic             out_free;
  logic             emit;
  rsp_t             emit_data;
  logic [AW-1:0]    raddr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [VAL_W-1:0] wr_data;
  logic [VAL_W-1:0] rdata0;
  logic [VAL_W-1:0] rdata1;
  logic [VAL_W-1:0] rdata_sel;

  logic [CW-1:0]    s_inc;
  logic             s_last;
  logic [AW-1:0]    dp_inc;
  logic [EW-1:0]    pos_x;
  logic [EW-1:0]    cnt_x;
  logic [EW-1:0]    fpos_x;
  logic             ins_ok;
  logic [AW-1:0]    ins_idx;
  logic             del_ok;
  logic [AW-1:0]    del_idx;
  logic             mod_start;
  logic             mod_done;
  logic [CW-1:0]    mod_rem;

  ale_ram #(.DEPTH(DEPTH), .AW(AW)) u_bank0 (
    .clk  (clk),
    .we   (wr_en && cur),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(raddr),
    .rdata(rdata0)
  );

  ale_ram #(.DEPTH(DEPTH), .AW(AW)) u_bank1 (
    .clk  (clk),
    .we   (wr_en && !cur),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(raddr),
    .rdata(rdata1)
  );

  ale_mod #(.CW(CW)) u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (mod_start),
    .dividend(op.rotate_amount),
    .divisor (cnt),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign rdata_sel = cur ? rdata1 : rdata0;

  assign s_inc  = CW'(s) + CW'(1);
  assign s_last = (s_inc == cnt);
  assign dp_inc = ((CW'(dp) + CW'(1)) == cnt) ? '0 : AW'(CW'(dp) + CW'(1));
  assign pos_x  = EW'(op.position);
  assign cnt_x  = EW'(cnt);
  assign fpos_x = EW'(s) + EW'(1);

  // insert and delete checks, index of the affected element
  always_comb begin
    ins_ok  = 1'b0;
    ins_idx = '0;
    del_ok  = 1'b0;
    del_idx = '0;
    unique case (op.action) inside
      ACT_INS_FRONT: ins_ok = (cnt_x < EW'(DEPTH));
      ACT_INS_END: begin
        ins_ok  = (cnt_x < EW'(DEPTH));
        ins_idx = AW'(cnt);
      end
      ACT_INS_POS: begin
        ins_ok  = (cnt_x < EW'(DEPTH)) && (pos_x != '0) && (pos_x <= cnt_x + EW'(1));
        ins_idx = AW'(pos_x - EW'(1));
      end
      ACT_DEL_FRONT: del_ok = (cnt != '0);
      ACT_DEL_POS: begin
        del_ok  = (cnt != '0) && (pos_x != '0) && (pos_x <= cnt_x);
        del_idx = AW'(pos_x - EW'(1));
      end
      default: begin
      end
    endcase
  end

  // bank access, remainder start and result word
  always_comb begin
    raddr     = '0;
    wr_en     = 1'b0;
    wr_addr   = s;
    wr_data   = rdata_sel;
    emit      = 1'b0;
    emit_data = '0;
    mod_start = 1'b0;
    unique case (state)
      S_DISP: begin
        if (ins_ok) begin
          wr_en   = 1'b1;
          wr_addr = ins_idx;
          wr_data = op.value;
        end
        mod_start = (op.action == ACT_ROTATE) && (cnt != '0);
      end
      S_COPY: begin
        raddr = AW'(s_inc);
        unique case (mode)
          M_INS: wr_addr = (s < idx) ? s : AW'(s_inc);
          M_DEL: begin
            wr_en   = (s != idx);
            wr_addr = (s < idx) ? s : AW'(CW'(s) - CW'(1));
          end
          default: wr_addr = dp;
        endcase
        if (mode != M_DEL) begin
          wr_en = 1'b1;
        end
      end
      S_SEARCH: raddr = AW'(s_inc);
      S_READ: begin
        // hold the address while the output is blocked so read data stays put
        raddr                  = out_free ? AW'(s_inc) : s;
        emit                   = out_free;
        emit_data.status       = ST_OK;
        emit_data.element      = rdata_sel;
        emit_data.count        = cnt_x[3:0];
        emit_data.last         = s_last;
      end
      S_RESP: begin
        emit                     = out_free;
        emit_data.status         = st;
        emit_data.found_position = fpos;
        emit_data.count          = cnt_x[3:0];
        emit_data.last           = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      cur       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (emit) begin
        rsp_valid <= 1'b1;
        rsp       <= emit_data;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op    <= req;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          fpos <= '0;
          s    <= '0;
          unique case (op.action) inside
            ACT_INS_FRONT, ACT_INS_END, ACT_INS_POS: begin
              if (ins_ok) begin
                st   <= ST_OK;
                idx  <= ins_idx;
                mode <= M_INS;
                if (cnt == '0) begin
                  cur   <= ~cur;
                  cnt   <= cnt + CW'(1);
                  state <= S_RESP;
                end else begin
                  state <= S_COPY;
                end
              end else begin
                st    <= (op.action == ACT_INS_POS) ? ST_BADPOS : ST_FULL;
                state <= S_RESP;
              end
            end
            ACT_DEL_FRONT, ACT_DEL_POS: begin
              if (del_ok) begin
                st   <= ST_OK;
                idx  <= del_idx;
                mode <= M_DEL;
                if (cnt == CW'(1)) begin
                  cnt   <= '0;
                  state <= S_RESP;
                end else begin
                  state <= S_COPY;
                end
              end else begin
                st    <= (op.action == ACT_DEL_FRONT) ? ST_EMPTY : ST_BADPOS;
                state <= S_RESP;
              end
            end
            ACT_DEL_END: begin
              if (cnt == '0) begin
                st <= ST_EMPTY;
              end else begin
                st  <= ST_OK;
                cnt <= cnt - CW'(1);
              end
              state <= S_RESP;
            end
            ACT_SEARCH: begin
              if (cnt == '0) begin
                st    <= ST_NOTFOUND;
                state <= S_RESP;
              end else begin
                st    <= ST_OK;
                state <= S_SEARCH;
              end
            end
            ACT_READOUT: begin
              if (cnt == '0) begin
                st    <= ST_EMPTY;
                state <= S_RESP;
              end else begin
                st    <= ST_OK;
                state <= S_READ;
              end
            end
            ACT_ROTATE: begin
              st    <= ST_OK;
              state <= (cnt == '0) ? S_RESP : S_MOD;
            end
            default: begin
              st    <= ST_OK;
              state <= S_RESP;
            end
          endcase
        end
        S_MOD: begin
          if (mod_done) begin
            if (mod_rem == '0) begin
              state <= S_RESP;
            end else begin
              dp    <= mod_rem[AW-1:0];
              s     <= '0;
              mode  <= M_ROT;
              state <= S_COPY;
            end
          end
        end
        S_COPY: begin
          if (s_last) begin
            cur <= ~cur;
            if (mode == M_INS) begin
              cnt <= cnt + CW'(1);
            end else if (mode == M_DEL) begin
              cnt <= cnt - CW'(1);
            end
            state <= S_RESP;
          end else begin
            s  <= AW'(s_inc);
            dp <= dp_inc;
          end
        end
        S_SEARCH: begin
          if (rdata_sel == op.value) begin
            fpos  <= fpos_x[3:0];
            state <= S_RESP;
          end else if (s_last) begin
            st    <= ST_NOTFOUND;
            state <= S_RESP;
          end else begin
            s <= AW'(s_inc);
          end
        end
        S_READ: begin
          if (out_free) begin
            if (s_last) begin
              state <= S_IDLE;
            end else begin
              s <= AW'(s_inc);
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    EW'(cnt) <= EW'(DEPTH))
    else $error("element count above depth");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == S_DISP))
    else $error("accepted word not dispatched");

  a_mod_owner: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == S_MOD))
    else $error("remainder finished outside rotate wait");

  a_copy_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY && wr_en) |-> (EW'(wr_addr) <= EW'(cnt)))
    else $error("copy writes beyond the new list");

  a_copy_flip: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY && s_last) |=> (cur != $past(cur)))
    else $error("bank not swapped after copy");
`endif

endmodule

### tb/ale_checker.sv
// list predictor and result checker for the array list engine testbench
module ale_checker #(
  parameter int DEPTH = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  ale_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  ale_pkg::rsp_t rsp,
  output int            fail_count,
  output int            pending,
  output int            occupancy
);
  import ale_pkg::*;

  logic signed [VAL_W-1:0] shadow_list [DEPTH];
  int                      shadow_len;
  rsp_t                    expected_words [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want_v);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want_v, $time);
    fail_count++;
  endtask

  task automatic push_word(input logic [2:0] st, input logic [3:0] fpos,
                           input logic signed [VAL_W-1:0] elem, input logic lst);
    rsp_t w;
    w.status         = st;
    w.found_position = fpos;
    w.element        = elem;
    w.count          = shadow_len[3:0];
    w.last           = lst;
    expected_words.push_back(w);
  endtask

  task automatic insert_entry(input int idx, input logic signed [VAL_W-1:0] v);
    for (int i = shadow_len; i > idx; i--) begin
      shadow_list[i] = shadow_list[i-1];
    end
    shadow_list[idx] = v;
    shadow_len++;
  endtask

  task automatic remove_entry(input int idx);
    for (int i = idx; i + 1 < shadow_len; i++) begin
      shadow_list[i] = shadow_list[i+1];
    end
    shadow_len--;
  endtask

  // updates the shadow list for one word and queues the words it should produce
  task automatic predict_list_op(input req_t w);
    logic signed [VAL_W-1:0] rotated [DEPTH];
    int                      k;
    logic [2:0]              st;
    logic [3:0]              fpos;
    st   = ST_OK;
    fpos = '0;
    case (w.action)
      ACT_INS_FRONT: begin
        if (shadow_len >= DEPTH) st = ST_FULL;
        else insert_entry(0, w.value);
      end
      ACT_INS_END: begin
        if (shadow_len >= DEPTH) st = ST_FULL;
        else insert_entry(shadow_len, w.value);
      end
      ACT_INS_POS: begin
        if (shadow_len >= DEPTH || w.position < 1 || w.position > shadow_len + 1)
          st = ST_BADPOS;
        else insert_entry(int'(w.position) - 1, w.value);
      end
      ACT_DEL_FRONT: begin
        if (shadow_len == 0) st = ST_EMPTY;
        else remove_entry(0);
      end
      ACT_DEL_END: begin
        if (shadow_len == 0) st = ST_EMPTY;
        else shadow_len--;
      end
      ACT_DEL_POS: begin
        if (shadow_len == 0 || w.position < 1 || w.position > shadow_len) st = ST_BADPOS;
        else remove_entry(int'(w.position) - 1);
      end
      ACT_SEARCH: begin
        st = ST_NOTFOUND;
        for (int i = 0; i < shadow_len; i++) begin
          if (st == ST_NOTFOUND && shadow_list[i] == w.value) begin
            st   = ST_OK;
            fpos = 4'(i + 1);
          end
        end
      end
      ACT_READOUT: begin
        if (shadow_len == 0) begin
          st = ST_EMPTY;
        end else begin
          for (int i = 0; i < shadow_len; i++) begin
            push_word(ST_OK, '0, shadow_list[i], (i + 1 == shadow_len));
          end
          return;
        end
      end
      ACT_ROTATE: begin
        if (shadow_len != 0) begin
          k = int'(w.rotate_amount) % shadow_len;
          for (int i = 0; i < shadow_len; i++) rotated[(i + k) % shadow_len] = shadow_list[i];
          for (int i = 0; i < shadow_len; i++) shadow_list[i] = rotated[i];
        end
      end
      default: ;
    endcase
    push_word(st, fpos, '0, 1'b1);
  endtask

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      shadow_len = 0;
      expected_words.delete();
    end else begin
      if (req_valid && !req_stall) predict_list_op(req);
      if (rsp_valid && !rsp_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch("word with nothing expected", 32'(rsp), '0);
        end else begin
          want = expected_words.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", 32'(rsp.status), 32'(want.status));
          if (rsp.found_position !== want.found_position)
            report_mismatch("found_position", 32'(rsp.found_position),
                            32'(want.found_position));
          if (rsp.element !== want.element)
            report_mismatch("element", rsp.element, want.element);
          if (rsp.count !== want.count)
            report_mismatch("count", 32'(rsp.count), 32'(want.count));
          if (rsp.last !== want.last)
            report_mismatch("last", 32'(rsp.last), 32'(want.last));
        end
      end
    end
    pending   <= expected_words.size();
    occupancy <= shadow_len;
  end

endmodule

### tb/tb.sv
// stimulus, clock, reset and verdict for the array list engine testbench
module tb;
  import ale_pkg::*;

  localparam logic [3:0] ACT_UNUSED_LO = 4'd9;
  localparam logic [3:0] ACT_UNUSED_HI = 4'd15;
  localparam int         RANDOM_OPS    = 95;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  int fail_count;
  int pending;
  int occupancy;
  int counted;
  bit quiet;

  logic signed [VAL_W-1:0] value_pool [8];

  array_list_engine_unit #(.DEPTH(8)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  ale_checker #(.DEPTH(8)) u_check (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending),
    .occupancy  (occupancy)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #3000000;
    $display("array_list_engine_unit verification failed");
    $finish;
  end

  function automatic req_t op_word(input logic [3:0] act, input logic [7:0] pos,
                                   input logic signed [VAL_W-1:0] v,
                                   input logic [AMT_W-1:0] amt);
    req_t w;
    w.action        = act;
    w.position      = pos;
    w.value         = v;
    w.rotate_amount = amt;
    return w;
  endfunction

  task automatic send_word(input req_t w);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  // mostly well-formed operations sized to the current fill, some noise
  task automatic send_random_op(output bit useful);
    logic [3:0]              act;
    logic [7:0]              pos;
    logic signed [VAL_W-1:0] v;
    logic [AMT_W-1:0]        amt;
    int                      sel;
    int                      pick;
    sel = $urandom_range(0, 99);
    if (occupancy >= 7 && sel < 35) sel = 35 + $urandom_range(0, 24);
    else if (occupancy <= 1 && sel >= 35 && sel < 60) sel = $urandom_range(0, 34);
    if (sel < 35)      act = 4'(ACT_INS_FRONT + $urandom_range(0, 2));
    else if (sel < 60) act = 4'(ACT_DEL_FRONT + $urandom_range(0, 2));
    else if (sel < 75) act = ACT_SEARCH;
    else if (sel < 83) act = ACT_READOUT;
    else if (sel < 96) act = ACT_ROTATE;
    else               act = 4'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
    pick = $urandom_range(0, 9);
    if (pick < 8)       pos = 8'($urandom_range(1, occupancy + 1));
    else if (pick == 8) pos = $urandom_range(0, 1) ? 8'd0 : 8'(occupancy + 2);
    else                pos = 8'($urandom_range(0, 255));
    v = ($urandom_range(0, 9) < 7) ? value_pool[$urandom_range(0, 7)] : $urandom;
    pick = $urandom_range(0, 9);
    if (pick < 5)      amt = 16'($urandom_range(0, 20));
    else if (pick < 8) amt = 16'($urandom_range(0, 65535));
    else               amt = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
    send_word(op_word(act, pos, v, amt));
    useful = (act <= ACT_ROTATE);
  endtask

  // receiver side: random stall ahead of each word
  initial begin : drain
    int n;
    rsp_stall = 1'b0;
    @(negedge rst);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 10);
      if (n > 0) begin
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!rsp_valid);
    end
  end

  initial begin : stimulus
    bit useful;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    quiet     = 1'b0;
    counted   = 0;
    value_pool[0] = 32'sd0;
    value_pool[1] = 32'sd1;
    value_pool[2] = -32'sd1;
    value_pool[3] = 32'sh7fffffff;
    value_pool[4] = 32'sh80000000;
    value_pool[5] = 32'sd7;
    value_pool[6] = -32'sd100;
    value_pool[7] = 32'sh5a5a5a5a;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list corner cases
    send_word(op_word(ACT_DEL_FRONT, 8'd0, 32'sd0, 16'd0));
    send_word(op_word(ACT_DEL_END, 8'd0, 32'sd0, 16'd0));
    send_word(op_word(ACT_DEL_POS, 8'd1, 32'sd0, 16'd0));
    send_word(op_word(ACT_READOUT, 8'd0, 32'sd0, 16'd0));
    send_word(op_word(ACT_SEARCH, 8'd0, 32'sd0, 16'd0));
    send_word(op_word(ACT_ROTATE, 8'd0, 32'sd0, 16'd5));
    send_word(op_word(ACT_INS_POS, 8'd0, 32'sd3, 16'd0));
    send_word(op_word(ACT_INS_POS, 8'd2, 32'sd3, 16'd0));
    // fill to capacity
    send_word(op_word(ACT_INS_FRONT, 8'd0, 32'sh80000000, 16'd0));
    send_word(op_word(ACT_INS_END, 8'd0, 32'sh7fffffff, 16'd0));
    send_word(op_word(ACT_INS_POS, 8'd2, -32'sd1, 16'd0));
    send_word(op_word(ACT_INS_POS, 8'd4, 32'sd0, 16'd0));
    send_word(op_word(ACT_INS_END, 8'd0, 32'sd1, 16'd0));
    send_word(op_word(ACT_INS_FRONT, 8'd0, 32'sd7, 16'd0));
    send_word(op_word(ACT_INS_POS, 8'd3, -32'sd100, 16'd0));
    send_word(op_word(ACT_INS_END, 8'd0, 32'sh5a5a5a5a, 16'd0));
    // full list rejections, then search, rotate and readout on the full list
    send_word(op_word(ACT_INS_FRONT, 8'd0, 32'sd9, 16'd0));
    send_word(op_word(ACT_INS_END, 8'd0, 32'sd9, 16'd0));
    send_word(op_word(ACT_INS_POS, 8'd1, 32'sd9, 16'd0));
    send_word(op_word(ACT_SEARCH, 8'd0, 32'sh7fffffff, 16'd0));
    send_word(op_word(ACT_SEARCH, 8'd0, 32'sd12345, 16'd0));
    send_word(op_word(ACT_ROTATE, 8'd0, 32'sd0, 16'hffff));
    send_word(op_word(ACT_ROTATE, 8'd0, 32'sd0, 16'd16));
    send_word(op_word(ACT_READOUT, 8'd0, 32'sd0, 16'd0));
    // bad delete positions, then good deletes and unused action codes
    send_word(op_word(ACT_DEL_POS, 8'd9, 32'sd0, 16'd0));
    send_word(op_word(ACT_DEL_POS, 8'd0, 32'sd0, 16'd0));
    send_word(op_word(ACT_DEL_POS, 8'd255, 32'sd0, 16'd0));
    send_word(op_word(ACT_DEL_POS, 8'd8, 32'sd0, 16'd0));
    send_word(op_word(ACT_DEL_FRONT, 8'd0, 32'sd0, 16'd0));
    send_word(op_word(ACT_DEL_END, 8'd0, 32'sd0, 16'd0));
    send_word(op_word(ACT_UNUSED_LO, 8'd1, 32'sd1, 16'd1));
    send_word(op_word(ACT_UNUSED_HI, 8'd255, -32'sd1, 16'hffff));

    while (counted < RANDOM_OPS) begin
      quiet = (counted >= 50 && counted < 75);
      send_random_op(useful);
      if (useful) counted++;
    end
    quiet = 1'b0;
    req_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("array_list_engine_unit verification clean");
    end else begin
      $display("array_list_engine_unit verification failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/ale_pkg.sv
hw/rtl/ale_ram.sv
hw/rtl/ale_mod.sv
hw/rtl/array_list_engine_unit.sv
tb/ale_checker.sv
tb/tb.sv
